[src/srrs_pkg.sv]
// Shared types, constants and the microcode table of the slope resistance ratio sequencer.
`timescale 1ns / 1ps

package srrs_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SCALE_W   = 8;
  localparam int REPORT_W  = 16;
  localparam int RATIO_W   = 24;
  localparam int DIV_STEPS = RATIO_W;
  localparam int STEP_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DISCHARGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARGE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd3;

  localparam logic [CFG_W-1:0]   DISCHARGE_RESET = 16'd33;
  localparam logic [CFG_W-1:0]   CHARGE_RESET    = 16'd32;
  localparam logic [CFG_W-1:0]   PERIOD_RESET    = 16'd32768;
  localparam logic [SCALE_W-1:0] SCALE_RESET     = 8'd100;

  localparam logic [STEP_W-1:0] STEP_IDLE      = 3'd0;
  localparam logic [STEP_W-1:0] STEP_EVAL      = 3'd1;
  localparam logic [STEP_W-1:0] STEP_DIV_START = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DIV_WAIT  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT      = 3'd4;

  typedef enum logic [3:0] {
    PH_DISCHARGE   = 4'b0001,
    PH_CHARGE      = 4'b0010,
    PH_COUNT_START = 4'b0100,
    PH_COUNTING    = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_EVAL,
    OP_DIV_START,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    JC_NONE,
    JC_NO_INPUT,
    JC_NO_PAIR,
    JC_DIV_BUSY,
    JC_OUT_FULL
  } jc_t;

  typedef struct packed {
    op_t               op;
    jc_t               cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic pair_done;
    logic div_busy;
    logic out_full;
  } flags_t;

  // One control word per step; a taken condition jumps to target, otherwise the
  // program falls through, or returns to the idle step after the last word.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
    ucode_t w;
    case (addr)
      STEP_IDLE:      w = '{op: OP_ACCEPT,    cond: JC_NO_INPUT, target: STEP_IDLE,     last: 1'b0};
      STEP_EVAL:      w = '{op: OP_EVAL,      cond: JC_NO_PAIR,  target: STEP_EMIT,     last: 1'b0};
      STEP_DIV_START: w = '{op: OP_DIV_START, cond: JC_NONE,     target: STEP_IDLE,     last: 1'b0};
      STEP_DIV_WAIT:  w = '{op: OP_NOP,       cond: JC_DIV_BUSY, target: STEP_DIV_WAIT, last: 1'b0};
      STEP_EMIT:      w = '{op: OP_EMIT,      cond: JC_OUT_FULL, target: STEP_EMIT,     last: 1'b1};
      default:        w = '{op: OP_NOP,       cond: JC_NONE,     target: STEP_IDLE,     last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

[src/srrs_sequencer.sv]
// Step counter and microcode fetch with conditional jumps.
`timescale 1ns / 1ps

module srrs_sequencer import srrs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  flags_t            flags,
  output ucode_t            uc,
  output logic [STEP_W-1:0] step
);

  logic [STEP_W-1:0] step_next;
  logic              take;

  assign uc = ucode_rom(step);

  always_comb begin
    unique case (uc.cond)
      JC_NONE:     take = 1'b0;
      JC_NO_INPUT: take = !flags.in_valid;
      JC_NO_PAIR:  take = !flags.pair_done;
      JC_DIV_BUSY: take = flags.div_busy;
      JC_OUT_FULL: take = flags.out_full;
      default:     take = 1'b0;
    endcase
    if (take) begin
      step_next = uc.target;
    end else if (uc.last) begin
      step_next = STEP_IDLE;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[src/srrs_divider.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module srrs_divider import srrs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [RATIO_W-1:0]  dividend,
  input  logic [REPORT_W-1:0] divisor,
  output logic                busy,
  output logic [RATIO_W-1:0]  quotient
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [CNT_W-1:0]    cnt;
  logic [REPORT_W-1:0] rem;
  logic [REPORT_W-1:0] dvs;
  logic [REPORT_W:0]   shifted;
  logic [REPORT_W:0]   diff;
  logic                fits;

  assign busy    = (cnt != '0);
  assign shifted = {rem, quotient[RATIO_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? diff[REPORT_W-1:0] : shifted[REPORT_W-1:0];
      quotient <= {quotient[RATIO_W-2:0], fits};
    end
  end

endmodule

[src/srrs_datapath.sv]
// Phase state, counters, configuration registers, multiply and output register.
`timescale 1ns / 1ps

module srrs_datapath import srrs_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ucode_t               uc,
  input  logic                 in_valid,
  input  logic                 cmp_above,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 out_stall,
  output flags_t               flags,
  output logic                 out_valid,
  output logic                 active_channel,
  output logic                 pin_level,
  output logic                 done_res,
  output logic [REPORT_W-1:0]  meas_count,
  output logic [REPORT_W-1:0]  ref_count,
  output logic [RATIO_W-1:0]   ratio,
  output logic                 div_by_zero
);

  localparam int XW   = (COUNT_WIDTH > REPORT_W) ? COUNT_WIDTH : REPORT_W;
  localparam int CMPW = XW + 1;

  logic [CFG_W-1:0]   discharge_ticks;
  logic [CFG_W-1:0]   charge_ticks;
  logic [CFG_W-1:0]   count_period;
  logic [SCALE_W-1:0] ratio_scale;

  phase_t                 phase, phase_next;
  logic                   channel, channel_next;
  logic [COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [COUNT_WIDTH-1:0] held_meas_count, held_meas_count_next;

  logic                above_q, chan_q, pin_q, done_q, dz_q;
  logic [REPORT_W-1:0] mc_q, rc_q;

  logic                   accept;
  logic                   out_full;
  logic [CMPW-1:0]        tc_inc;
  logic                   tc_max, dis_over, chg_over, wrap;
  logic [COUNT_WIDTH-1:0] tc_step, tc_cnt;
  logic [XW-1:0]          tc_ext, held_ext;
  logic                   ev_done;
  logic [REPORT_W-1:0]    ev_mc, ev_rc;
  logic                   div_busy;
  logic [RATIO_W-1:0]     quotient;
  logic [RATIO_W-1:0]     product;

  assign accept   = in_valid && (uc.op == OP_ACCEPT);
  assign out_full = out_valid && out_stall;

  assign flags = '{in_valid: in_valid, pair_done: ev_done, div_busy: div_busy,
                   out_full: out_full};

  always_ff @(posedge clk) begin
    if (rst) begin
      discharge_ticks <= DISCHARGE_RESET;
      charge_ticks    <= CHARGE_RESET;
      count_period    <= PERIOD_RESET;
      ratio_scale     <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DISCHARGE: discharge_ticks <= cfg_data;
        CFG_CHARGE:    charge_ticks    <= cfg_data;
        CFG_PERIOD:    count_period    <= cfg_data;
        CFG_SCALE:     ratio_scale     <= cfg_data[SCALE_W-1:0];
        default:       ;
      endcase
    end
  end

  // Timed phases also end when a narrow counter reaches all ones.
  always_comb begin
    tc_inc   = CMPW'(tick_count) + CMPW'(1);
    tc_max   = &tick_count;
    dis_over = (tc_inc >= CMPW'(discharge_ticks)) || tc_max;
    chg_over = (tc_inc >= CMPW'(charge_ticks)) || tc_max;
    tc_ext   = XW'(tick_count);
    held_ext = XW'(held_meas_count);
    wrap     = (tc_ext >= XW'(count_period));
    tc_step  = tick_count + COUNT_WIDTH'(1);
    tc_cnt   = wrap ? '0 : tc_step;

    phase_next           = phase;
    channel_next         = channel;
    tick_count_next      = tick_count;
    held_meas_count_next = held_meas_count;
    ev_done              = 1'b0;
    ev_mc                = '0;
    ev_rc                = '0;

    unique case (phase)
      PH_DISCHARGE: begin
        if (dis_over) begin
          phase_next      = PH_CHARGE;
          tick_count_next = '0;
        end else begin
          tick_count_next = tc_step;
        end
      end
      PH_CHARGE: begin
        if (chg_over) begin
          phase_next      = PH_COUNT_START;
          tick_count_next = '0;
        end else begin
          tick_count_next = tc_step;
        end
      end
      PH_COUNT_START: begin
        // A comparator already low means the charge did not take; start over.
        if (!above_q) begin
          phase_next      = PH_DISCHARGE;
          tick_count_next = '0;
        end else begin
          phase_next      = PH_COUNTING;
          tick_count_next = tc_cnt;
        end
      end
      PH_COUNTING: begin
        if (above_q) begin
          tick_count_next = tc_cnt;
        end else if (!channel) begin
          held_meas_count_next = tick_count;
          channel_next         = 1'b1;
          phase_next           = PH_DISCHARGE;
          tick_count_next      = '0;
        end else begin
          ev_done         = 1'b1;
          ev_mc           = held_ext[REPORT_W-1:0];
          ev_rc           = tc_ext[REPORT_W-1:0];
          channel_next    = 1'b0;
          phase_next      = PH_DISCHARGE;
          tick_count_next = '0;
        end
      end
      default: begin
        phase_next      = PH_DISCHARGE;
        tick_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_DISCHARGE;
      channel         <= 1'b0;
      tick_count      <= '0;
      held_meas_count <= '0;
    end else if (uc.op == OP_EVAL) begin
      phase           <= phase_next;
      channel         <= channel_next;
      tick_count      <= tick_count_next;
      held_meas_count <= held_meas_count_next;
    end
  end

  // The beat's pin fields show the state before the tick is applied.
  always_ff @(posedge clk) begin
    if (accept) begin
      above_q <= cmp_above;
      chan_q  <= channel;
      pin_q   <= (phase == PH_CHARGE);
    end
    if (uc.op == OP_EVAL) begin
      done_q <= ev_done;
      mc_q   <= ev_mc;
      rc_q   <= ev_rc;
      dz_q   <= ev_done && (ev_rc == '0);
    end
  end

  // 8 x 16 bits always fits 24 bits, so the quotient never needs saturation.
  assign product = RATIO_W'(ratio_scale) * RATIO_W'(mc_q);

  srrs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (uc.op == OP_DIV_START),
    .dividend (product),
    .divisor  (rc_q),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (uc.op == OP_EMIT && !out_full) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.op == OP_EMIT && !out_full) begin
      active_channel <= chan_q;
      pin_level      <= pin_q;
      done_res       <= done_q;
      meas_count     <= mc_q;
      ref_count      <= rc_q;
      ratio          <= (done_q && !dz_q) ? quotient : '0;
      div_by_zero    <= dz_q;
    end
  end

endmodule

[src/slope_resistance_ratio_sequencer.sv]
// Top level of the slope resistance ratio sequencer.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall    cmp_above
//   out      output     out_valid / out_stall  active_channel, pin_level, done_res,
//                                              meas_count, ref_count, ratio, div_by_zero
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// A tick beat passes the evaluate and emit steps from acceptance to its result beat;
// the tick that closes a measurement pair also waits on the bit-serial divider.
// One tick is worked on at a time; the next is accepted while a result waits in the
// output register. A stalled output holds the program at its emit step.
// Reset is synchronous and restores the register reset values and the discharge phase
// of the unknown channel.
`timescale 1ns / 1ps

module slope_resistance_ratio_sequencer import srrs_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cmp_above,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 active_channel,
  output logic                 pin_level,
  output logic                 done_res,
  output logic [REPORT_W-1:0]  meas_count,
  output logic [REPORT_W-1:0]  ref_count,
  output logic [RATIO_W-1:0]   ratio,
  output logic                 div_by_zero,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  ucode_t            uc;
  flags_t            flags;
  logic [STEP_W-1:0] step;

  assign in_stall = (uc.op != OP_ACCEPT);

  srrs_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .uc    (uc),
    .step  (step)
  );

  srrs_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .uc             (uc),
    .in_valid       (in_valid),
    .cmp_above      (cmp_above),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_stall      (out_stall),
    .flags          (flags),
    .out_valid      (out_valid),
    .active_channel (active_channel),
    .pin_level      (pin_level),
    .done_res       (done_res),
    .meas_count     (meas_count),
    .ref_count      (ref_count),
    .ratio          (ratio),
    .div_by_zero    (div_by_zero)
  );

  a_accept_to_eval: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (step == STEP_EVAL))
    else $error("accepted tick did not move the program to its evaluate step");

  a_zero_ref_ratio: assert property (@(posedge clk) disable iff (rst)
    (out_valid && div_by_zero) |-> (done_res && ratio == '0 && ref_count == '0))
    else $error("zero reference beat carries a ratio or count");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !done_res) |-> (meas_count == '0 && ref_count == '0 && ratio == '0
                                  && !div_by_zero))
    else $error("beat without a finished pair carries result fields");

endmodule
